// ===== rtl/core/pulse_width_uart_receiver_unit_macros.svh =====
// assertion helpers for the pulse width uart receiver
`ifndef PULSE_WIDTH_UART_RECEIVER_UNIT_MACROS_SVH
`define PULSE_WIDTH_UART_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PWUR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PWUR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pwur_pkg.sv =====
package pwur_pkg;

    localparam int BAUD_W     = 22;
    localparam int TICK_W     = 27;
    localparam int CFG_DATA_W = 27;
    localparam int CFG_IDX_W  = 2;
    localparam int DATA_W     = 8;
    localparam int POS_W      = 5;
    localparam int FRAME_W    = 11;
    localparam int ONES_W     = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BAUD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd2;

    localparam logic [BAUD_W-1:0] BAUD_RESET = 22'd115200;
    localparam logic [TICK_W-1:0] TICK_RESET = 27'd10000000;

    // frame geometry per format
    localparam logic [POS_W-1:0]   INFO_W_8N1    = 5'd8;
    localparam logic [POS_W-1:0]   INFO_W_8E2    = 5'd9;
    localparam logic [POS_W-1:0]   TOTAL_W_8N1   = 5'd9;
    localparam logic [POS_W-1:0]   TOTAL_W_8E2   = 5'd11;
    localparam logic [FRAME_W-1:0] STOP_MASK_8N1 = 11'h100;
    localparam logic [FRAME_W-1:0] STOP_MASK_8E2 = 11'h600;

    typedef enum logic {
        FMT_8N1 = 1'b0,
        FMT_8E2 = 1'b1
    } frame_format_t;

    localparam frame_format_t FORMAT_RESET = FMT_8N1;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_PARITY = 2'd1,
        STAT_STOP   = 2'd2
    } frame_status_t;

    typedef struct packed {
        logic               produced;
        logic [DATA_W-1:0]  data;
        frame_status_t      status;
    } frame_result_t;

endpackage

// ===== rtl/core/pwur_divider.sv =====
module pwur_divider
    import pwur_pkg::*;
#(
    parameter int DURATION_WIDTH = 15,
    parameter int MAX_RUN_BITS   = 15
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [DURATION_WIDTH-1:0]         dur,
    input  logic [BAUD_W-1:0]                 baud,
    input  logic [TICK_W-1:0]                 tick,
    output logic                              done,
    output logic [$clog2(MAX_RUN_BITS+1)-1:0] cnt
);

    localparam int CNT_W  = $clog2(MAX_RUN_BITS + 1);
    localparam int PROD_W = DURATION_WIDTH + BAUD_W;
    // dividend carries one extra zero bit so the last quotient bit is the rounding bit
    localparam int DVD_W  = PROD_W + 1;
    localparam int STEPS  = DVD_W;
    localparam int STEP_W = $clog2(STEPS);
    localparam int Q_W    = CNT_W + 1;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [TICK_W-1:0] rem_reg;
    logic [Q_W-1:0]    q_reg;
    logic              sticky_reg;

    logic [TICK_W:0]   trial;
    logic [TICK_W+1:0] diff;
    logic              ge;
    logic [TICK_W-1:0] rem_step;
    logic              last;
    logic [Q_W:0]      rounded;
    logic              sat;

    // one restoring step per cycle
    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff     = {1'b0, trial} - {2'b00, tick};
    assign ge       = !diff[TICK_W+1];
    assign rem_step = ge ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
    assign last     = (step_reg == STEP_W'(STEPS - 1));

    // q holds floor(2*prod/tick); round half up by (q+1)/2
    assign rounded = ({1'b0, q_reg} + (Q_W+1)'(1)) >> 1;
    assign sat     = sticky_reg || (rounded > (Q_W+1)'(MAX_RUN_BITS));
    assign cnt     = sat ? CNT_W'(MAX_RUN_BITS) : rounded[CNT_W-1:0];
    assign done    = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg    <= {PROD_W'(dur) * PROD_W'(baud), 1'b0};
            rem_reg    <= '0;
            q_reg      <= '0;
            sticky_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg    <= dvd_reg << 1;
            rem_reg    <= rem_step;
            q_reg      <= {q_reg[Q_W-2:0], ge};
            sticky_reg <= sticky_reg | q_reg[Q_W-1];
        end
    end

endmodule

// ===== rtl/core/pwur_frame.sv =====
module pwur_frame
    import pwur_pkg::*;
#(
    parameter int CNT_W = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             apply,
    input  logic [CNT_W-1:0] cnt,
    input  logic             level,
    input  logic             batch,
    input  frame_format_t    format,
    output frame_result_t    result
);

    localparam int SUM_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    logic               hunt_reg,  hunt_next;
    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic [FRAME_W-1:0] bits_reg,  bits_next;
    logic [ONES_W-1:0]  ones_reg,  ones_next;

    logic               parity_on;
    logic [POS_W-1:0]   info_w;
    logic [POS_W-1:0]   total_w;
    logic [FRAME_W-1:0] stop_mask;
    logic [SUM_W-1:0]   pos_x, info_x, total_x, cnt_x;
    logic [SUM_W-1:0]   eff_cnt, next_pos, room, oc;
    logic [FRAME_W-1:0] mask;
    logic               active;

    assign parity_on = (format == FMT_8E2);
    assign info_w    = parity_on ? INFO_W_8E2 : INFO_W_8N1;
    assign total_w   = parity_on ? TOTAL_W_8E2 : TOTAL_W_8N1;
    assign stop_mask = parity_on ? STOP_MASK_8E2 : STOP_MASK_8N1;
    assign pos_x     = SUM_W'(pos_reg);
    assign info_x    = SUM_W'(info_w);
    assign total_x   = SUM_W'(total_w);
    assign cnt_x     = SUM_W'(cnt);

    always_comb
    begin
        hunt_next = hunt_reg;
        pos_next  = pos_reg;
        bits_next = bits_reg;
        ones_next = ones_reg;
        active    = 1'b0;
        next_pos  = pos_x;
        eff_cnt   = cnt_x;
        room      = '0;
        oc        = '0;
        mask      = '0;
        result    = '{produced: 1'b0, data: '0, status: STAT_OK};

        if (hunt_reg)
        begin
            // a low run of at least one bit holds the start bit
            if (!level && (cnt_x != '0))
            begin
                hunt_next = 1'b0;
                bits_next = '0;
                ones_next = '0;
                next_pos  = cnt_x - SUM_W'(1);
                active    = 1'b1;
            end
        end
        else
        begin
            if (level)
            begin
                // zero-length high run pads the rest of the frame
                if ((pos_x <= info_x) && (cnt_x == '0))
                begin
                    eff_cnt = total_x - pos_x;
                end
                if (parity_on && (pos_x < info_x))
                begin
                    room      = info_x - pos_x;
                    oc        = (eff_cnt > room) ? room : eff_cnt;
                    ones_next = ones_reg + oc[ONES_W-1:0];
                end
                for (int i = 0; i < FRAME_W; i++)
                begin
                    mask[i] = (SUM_W'(i) >= pos_x) && (SUM_W'(i) < pos_x + eff_cnt);
                end
                bits_next = bits_reg | mask;
            end
            next_pos = pos_x + eff_cnt;
            active   = 1'b1;
        end

        if (active)
        begin
            if (next_pos >= total_x)
            begin
                result.produced = 1'b1;
                result.data     = bits_next[DATA_W-1:0];
                if (parity_on && ones_next[0])
                begin
                    result.status = STAT_PARITY;
                end
                else if ((bits_next & stop_mask) != stop_mask)
                begin
                    result.status = STAT_STOP;
                end
                hunt_next = 1'b1;
                pos_next  = '0;
                bits_next = '0;
                ones_next = '0;
            end
            else
            begin
                pos_next = next_pos[POS_W-1:0];
            end
        end

        if (batch)
        begin
            hunt_next = 1'b1;
            pos_next  = '0;
            bits_next = '0;
            ones_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunt_reg <= 1'b1;
            pos_reg  <= '0;
            bits_reg <= '0;
            ones_reg <= '0;
        end
        else if (apply)
        begin
            hunt_reg <= hunt_next;
            pos_reg  <= pos_next;
            bits_reg <= bits_next;
            ones_reg <= ones_next;
        end
    end

endmodule

// ===== rtl/core/pulse_width_uart_receiver_unit.sv =====
// an input transfer starts the divider; its bit count then updates the frame and any finished
// frame goes to the output register; one symbol is in work at a time, the pace set by the
//   bit-serial divider that takes one quotient bit per cycle over the product width plus one
// a finished result waiting in the output register adds stall only if the next symbol is done
// reset: rst_n asynchronous active low; clears frame state to start hunting and loads
//   default baud, tick rate and 8N1 format; no memory and no clearing pass
module pulse_width_uart_receiver_unit
    import pwur_pkg::*;
#(
    parameter int MAX_RUN_BITS   = 15,
    parameter int DURATION_WIDTH = 15
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    // symbol input channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [DURATION_WIDTH-1:0] duration_ticks,
    input  logic                      line_level,
    input  logic                      batch_end,

    // result output channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [DATA_W-1:0]         data_byte,
    output logic [1:0]                frame_status,

    // configuration write port
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    localparam int CNT_W = $clog2(MAX_RUN_BITS + 1);

    // sequencer: idle, run the divider, apply the bit count to the frame
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    state_t            state_reg, state_next;

    // configuration registers
    logic [BAUD_W-1:0] baud_reg;
    logic [TICK_W-1:0] tick_reg;
    frame_format_t     format_reg;

    // symbol fields held while the divider runs
    logic              level_reg;
    logic              batch_reg;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] data_reg;
    frame_status_t     status_reg;

    logic              in_xfer;
    logic              out_xfer;
    logic              slot_free;
    logic              apply;
    logic              div_done;
    logic [CNT_W-1:0]  div_cnt;
    frame_result_t     frame_res;

    // a new symbol is taken only while the sequencer idles
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    // the frame update waits until the output register can take a result
    assign slot_free = !out_valid_reg || !out_stall;
    assign apply     = (state_reg == ST_UPD) && slot_free;

    assign out_valid    = out_valid_reg;
    assign data_byte    = data_reg;
    assign frame_status = status_reg;

    // shared serial unit: rounded duration * baud / tick, saturated
    pwur_divider #(
        .DURATION_WIDTH (DURATION_WIDTH),
        .MAX_RUN_BITS   (MAX_RUN_BITS)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_xfer),
        .dur   (duration_ticks),
        .baud  (baud_reg),
        .tick  (tick_reg),
        .done  (div_done),
        .cnt   (div_cnt)
    );

    // frame assembly state and status decision
    pwur_frame #(
        .CNT_W (CNT_W)
    ) u_frame (
        .clk    (clk),
        .rst_n  (rst_n),
        .apply  (apply),
        .cnt    (div_cnt),
        .level  (level_reg),
        .batch  (batch_reg),
        .format (format_reg),
        .result (frame_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
        if (apply && frame_res.produced)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            baud_reg      <= BAUD_RESET;
            tick_reg      <= TICK_RESET;
            format_reg    <= FORMAT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            // writes to an index past the register list are dropped
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BAUD:   baud_reg   <= cfg_data[BAUD_W-1:0];
                    CFG_TICK:   tick_reg   <= cfg_data[TICK_W-1:0];
                    CFG_FORMAT: format_reg <= frame_format_t'(cfg_data[0]);
                    default:    ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            level_reg <= line_level;
            batch_reg <= batch_end;
        end
        if (apply && frame_res.produced)
        begin
            data_reg   <= frame_res.data;
            status_reg <= frame_res.status;
        end
    end

endmodule

// ===== rtl/core/pwur_checker.sv =====
`include "pulse_width_uart_receiver_unit_macros.svh"

module pwur_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] data_byte,
    input logic [1:0] frame_status
);

    // a symbol transfer keeps the input stalled while the divider runs
    `PWUR_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall ##1 in_stall, "input not stalled after transfer")

    // a result appears only at the end of work on a symbol
    `PWUR_ASSERT_IMPL(a_result_from_work, $rose(out_valid), $past(in_stall), "result without symbol in work")

    // a stalled result holds
    `PWUR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(data_byte) && $stable(frame_status), "stalled result changed")

endmodule

bind pulse_width_uart_receiver_unit pwur_checker u_pwur_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_byte    (data_byte),
    .frame_status (frame_status)
);

// ===== sim/tb_pulse_width_uart_receiver_unit.sv =====
module tb_pulse_width_uart_receiver_unit;
    import pwur_pkg::*;

    localparam int DUR_W         = 15;
    localparam int RUN_LIMIT     = 15;
    // settle wait covers the worst case from symbol transfer to result, with margin
    localparam int SETTLE_CYCLES = 60;

    // one run-length line symbol as the sender sees it
    typedef struct {
        logic [DUR_W-1:0] dur;
        logic             level;
        logic             batch;
    } line_symbol_t;

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   in_valid       = 1'b0;
    logic                   in_stall;
    logic [DUR_W-1:0]       duration_ticks = '0;
    logic                   line_level     = 1'b0;
    logic                   batch_end      = 1'b0;
    logic                   out_valid;
    logic                   out_stall      = 1'b0;
    logic [DATA_W-1:0]      data_byte;
    logic [1:0]             frame_status;
    logic                   cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index      = '0;
    logic [CFG_DATA_W-1:0]  cfg_data       = '0;

    // register copies as the block should hold them
    logic [BAUD_W-1:0]      baud_cfg = BAUD_RESET;
    logic [TICK_W-1:0]      tick_cfg = TICK_RESET;
    frame_format_t          fmt_cfg  = FORMAT_RESET;

    // frame rebuild state as the block should hold it
    logic                   hunting   = 1'b1;
    logic [POS_W-1:0]       frame_pos = '0;
    logic [FRAME_W-1:0]     frame_acc = '0;
    logic [ONES_W-1:0]      ones_seen = '0;

    line_symbol_t           symbols_to_send [$];
    frame_result_t          frames_due [$];
    line_symbol_t           next_sym;
    frame_result_t          decoded;
    frame_result_t          want;
    logic                   symbol_taken   = 1'b0;
    int                     symbols_owed   = 0;
    int                     symbols_pushed = 0;
    int                     failures       = 0;
    int                     send_idle_pct  = 0;
    int                     recv_stall_pct = 0;

    pulse_width_uart_receiver_unit #(
        .MAX_RUN_BITS   (RUN_LIMIT),
        .DURATION_WIDTH (DUR_W)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .duration_ticks (duration_ticks),
        .line_level     (line_level),
        .batch_end      (batch_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .data_byte      (data_byte),
        .frame_status   (frame_status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs or drops a result
    initial
    begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // rounded bit count of one run, saturated
    function automatic logic [POS_W-1:0] bits_in_run(input logic [DUR_W-1:0] dur);
        logic [63:0] prod;
        logic [63:0] quo;
        logic [63:0] rem;
        if (tick_cfg == '0)
            return POS_W'(RUN_LIMIT);
        prod = 64'(dur) * 64'(baud_cfg);
        quo  = prod / 64'(tick_cfg);
        rem  = prod % 64'(tick_cfg);
        quo  = quo + (rem << 1) / 64'(tick_cfg);
        if (quo > 64'(RUN_LIMIT))
            quo = 64'(RUN_LIMIT);
        return quo[POS_W-1:0];
    endfunction

    // advance the frame rebuild by one symbol, return the finished frame if any
    function automatic frame_result_t decode_symbol(input logic [DUR_W-1:0] dur,
                                                    input logic level, input logic batch);
        logic               parity_on;
        logic [POS_W-1:0]   info_w;
        logic [POS_W-1:0]   total_w;
        logic [FRAME_W-1:0] stop_mask;
        logic [POS_W-1:0]   cnt;
        logic [POS_W-1:0]   oc;
        logic [5:0]         next_pos;
        logic [31:0]        run_mask;
        logic               active;
        frame_result_t      res;
        parity_on = (fmt_cfg == FMT_8E2);
        info_w    = parity_on ? INFO_W_8E2 : INFO_W_8N1;
        total_w   = parity_on ? TOTAL_W_8E2 : TOTAL_W_8N1;
        stop_mask = parity_on ? STOP_MASK_8E2 : STOP_MASK_8N1;
        cnt       = bits_in_run(dur);
        next_pos  = '0;
        active    = 1'b0;
        res       = '0;
        res.status = STAT_OK;
        if (hunting)
        begin
            // a low run of at least one bit holds the start bit
            if (!level && cnt != '0)
            begin
                hunting   = 1'b0;
                frame_acc = '0;
                ones_seen = '0;
                next_pos  = 6'(cnt) - 6'd1;
                active    = 1'b1;
            end
        end
        else
        begin
            if (level)
            begin
                // zero-length high run pads the frame with ones
                if (frame_pos <= info_w && cnt == '0)
                    cnt = total_w - frame_pos;
                if (parity_on && frame_pos < info_w)
                begin
                    oc = cnt;
                    if (oc > info_w - frame_pos)
                        oc = info_w - frame_pos;
                    ones_seen = ones_seen + oc[ONES_W-1:0];
                end
                run_mask  = ((32'd1 << cnt) - 32'd1) << frame_pos;
                frame_acc = frame_acc | run_mask[FRAME_W-1:0];
            end
            next_pos = 6'(frame_pos) + 6'(cnt);
            active   = 1'b1;
        end
        if (active)
        begin
            if (next_pos >= 6'(total_w))
            begin
                res.produced = 1'b1;
                res.data     = frame_acc[DATA_W-1:0];
                // parity wins over a bad stop bit
                if (parity_on && ones_seen[0])
                    res.status = STAT_PARITY;
                else if ((frame_acc & stop_mask) != stop_mask)
                    res.status = STAT_STOP;
                else
                    res.status = STAT_OK;
                hunting   = 1'b1;
                frame_pos = '0;
                frame_acc = '0;
                ones_seen = '0;
            end
            else
                frame_pos = next_pos[POS_W-1:0];
        end
        if (batch)
        begin
            hunting   = 1'b1;
            frame_pos = '0;
            frame_acc = '0;
            ones_seen = '0;
        end
        return res;
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endfunction

    // sample side: result check, symbol transfer bookkeeping, register capture
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (frames_due.size() == 0)
                    note_failure($sformatf("unexpected frame: data %02h status %0d",
                                           data_byte, frame_status));
                else
                begin
                    want = frames_due.pop_front();
                    if (data_byte !== want.data || frame_status !== want.status)
                        note_failure($sformatf(
                            "frame mismatch: expected data %02h status %0d, got data %02h status %0d",
                            want.data, want.status, data_byte, frame_status));
                end
            end
            symbol_taken = in_valid && !in_stall;
            if (symbol_taken)
            begin
                decoded = decode_symbol(duration_ticks, line_level, batch_end);
                if (decoded.produced)
                    frames_due.push_back(decoded);
                symbols_owed--;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BAUD:   baud_cfg = cfg_data[BAUD_W-1:0];
                    CFG_TICK:   tick_cfg = cfg_data[TICK_W-1:0];
                    CFG_FORMAT: fmt_cfg  = frame_format_t'(cfg_data[0]);
                    default:    ;
                endcase
            end
        end
    end

    // drive side: new symbol only after the previous transfer, random sender gaps
    // and receiver stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || symbol_taken)
            begin
                if (symbols_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_sym = symbols_to_send.pop_front();
                    in_valid       <= 1'b1;
                    duration_ticks <= next_sym.dur;
                    line_level     <= next_sym.level;
                    batch_end      <= next_sym.batch;
                end
                else
                begin
                    // payload is don't-care while idle, so scramble it
                    in_valid       <= 1'b0;
                    duration_ticks <= DUR_W'($urandom);
                    line_level     <= 1'($urandom);
                    batch_end      <= 1'($urandom);
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic push_symbol(input logic [DUR_W-1:0] dur, input logic level,
                               input logic batch);
        line_symbol_t s;
        s.dur   = dur;
        s.level = level;
        s.batch = batch;
        symbols_to_send.push_back(s);
        symbols_owed++;
        symbols_pushed++;
    endtask

    // duration for a number of bit times at the current rates, with jitter
    // well inside the rounding window
    function automatic logic [DUR_W-1:0] ticks_for(input int nbits);
        real span;
        real d;
        span = real'(tick_cfg) / real'(baud_cfg);
        d = nbits * span + (real'($urandom_range(60)) - 30.0) / 100.0 * span;
        if (d < 0.0)
            d = 0.0;
        if (d > 32767.0)
            d = 32767.0;
        return DUR_W'(int'(d));
    endfunction

    // encode one serial frame as line runs; tail 0 exact, 1 merged with idle,
    // 2 zero-length pad, 3 random
    task automatic push_frame(input logic [7:0] value, input bit spoil_stop,
                              input bit spoil_parity, input bit cut_short, input int tail);
        logic             line_bits [0:11];
        logic             run_lvl [0:11];
        int               run_len [0:11];
        int               run_at [0:11];
        int               i;
        int               n_line;
        int               n_runs;
        int               keep;
        int               tail_mode;
        int               info_w;
        bit               parity_on;
        logic [DUR_W-1:0] dur;
        parity_on = (fmt_cfg == FMT_8E2);
        info_w    = int'(parity_on ? INFO_W_8E2 : INFO_W_8N1);
        n_line    = int'(parity_on ? TOTAL_W_8E2 : TOTAL_W_8N1) + 1;
        line_bits[0] = 1'b0;
        for (i = 0; i < 8; i++)
            line_bits[i + 1] = value[i];
        if (parity_on)
            line_bits[9] = (^value) ^ spoil_parity;
        for (i = info_w + 1; i < n_line; i++)
            line_bits[i] = 1'b1;
        if (spoil_stop)
            line_bits[$urandom_range(n_line - 1, info_w + 1)] = 1'b0;
        n_runs = 0;
        for (i = 0; i < n_line; i++)
        begin
            if (i == 0 || line_bits[i] != line_bits[i - 1])
            begin
                run_lvl[n_runs] = line_bits[i];
                run_len[n_runs] = 0;
                run_at[n_runs]  = i;
                n_runs++;
            end
            run_len[n_runs - 1]++;
        end
        keep = n_runs;
        if (cut_short && n_runs > 1)
            keep = $urandom_range(n_runs - 1, 1);
        for (i = 0; i < keep; i++)
        begin
            if (i == n_runs - 1 && run_lvl[i])
            begin
                tail_mode = (tail > 2) ? $urandom_range(2) : tail;
                // padding only works while the position is inside the info bits
                if (tail_mode == 2 && run_at[i] - 1 <= info_w)
                    dur = '0;
                else if (tail_mode == 1)
                    dur = ticks_for(run_len[i] + $urandom_range(20, 1));
                else
                    dur = ticks_for(run_len[i]);
            end
            else
                dur = ticks_for(run_len[i]);
            push_symbol(dur, run_lvl[i],
                        (i == keep - 1) && !cut_short && ($urandom_range(7) == 0));
        end
        if (cut_short)
            push_symbol(DUR_W'($urandom), 1'($urandom), 1'b1);
        else if (!run_lvl[n_runs - 1])
            push_symbol(ticks_for($urandom_range(12, 1)), 1'b1, 1'b0);
    endtask

    // mostly clean frames with random content, some truncated, some line noise
    task automatic random_traffic(input int budget);
        int          stop_at;
        int          pick;
        logic [7:0]  value;
        stop_at = symbols_pushed + budget;
        while (symbols_pushed < stop_at)
        begin
            pick  = $urandom_range(99);
            value = 8'($urandom);
            if ($urandom_range(9) == 0)
                value = $urandom_range(1) ? 8'hFF : 8'h00;
            if (pick < 70)
                push_frame(value, $urandom_range(9) == 0, $urandom_range(9) == 0, 1'b0, 3);
            else if (pick < 85)
                push_frame(value, 1'b0, 1'b0, 1'b1, 3);
            else
                push_symbol(DUR_W'($urandom), 1'($urandom), $urandom_range(7) == 0);
        end
    endtask

    // hold the sender until every symbol went out and every frame came back,
    // then let the block go quiet
    task automatic settle();
        while (symbols_owed != 0 || frames_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sender idles lightly, receiver stalls heavily
        send_idle_pct  = 30;
        recv_stall_pct = 62;

        // reset rates, 8N1: hunting corner cases first
        push_symbol('0, 1'b0, 1'b0);            // zero-length low, still hunting
        push_symbol(ticks_for(3), 1'b1, 1'b0);  // high while hunting is ignored
        push_symbol('1, 1'b0, 1'b0);            // long low fills the whole frame
        push_frame(8'h00, 1'b0, 1'b0, 1'b0, 0);
        push_frame(8'hFF, 1'b0, 1'b0, 1'b0, 1);
        push_frame(8'hA5, 1'b0, 1'b0, 1'b0, 2);
        push_frame(8'h3C, 1'b1, 1'b0, 1'b0, 0); // stop bit low
        push_symbol(ticks_for(1), 1'b0, 1'b1);  // batch end right after a start
        push_symbol(ticks_for(2), 1'b1, 1'b0);
        settle();
        random_traffic(100);
        settle();

        // 8E2 at a slower line rate
        write_reg(CFG_FORMAT, CFG_DATA_W'(FMT_8E2));
        write_reg(CFG_BAUD, CFG_DATA_W'(9600));
        write_reg(CFG_TICK, CFG_DATA_W'(1000000));
        push_frame(8'h55, 1'b0, 1'b1, 1'b0, 2); // parity error with padding
        push_frame(8'h80, 1'b0, 1'b0, 1'b0, 0);
        random_traffic(100);
        settle();

        // roles swapped: sender idles heavily, receiver stalls lightly
        send_idle_pct  = 62;
        recv_stall_pct = 30;
        write_reg(CFG_BAUD, CFG_DATA_W'({BAUD_W{1'b1}}));
        write_reg(CFG_TICK, {TICK_W{1'b1}});
        write_reg(CFG_FORMAT, CFG_DATA_W'(FMT_8N1));
        random_traffic(100);
        settle();

        // one tick per bit, 8E2
        write_reg(CFG_BAUD, CFG_DATA_W'(1));
        write_reg(CFG_TICK, CFG_DATA_W'(1));
        write_reg(CFG_FORMAT, CFG_DATA_W'(FMT_8E2));
        // zero-length high once the stop bits have begun leaves the frame alone
        push_symbol(DUR_W'(1), 1'b0, 1'b0);
        push_symbol(DUR_W'(8), 1'b1, 1'b0);
        push_symbol(DUR_W'(1), 1'b0, 1'b0);
        push_symbol(DUR_W'(1), 1'b1, 1'b0);
        push_symbol('0, 1'b1, 1'b0);
        push_symbol(DUR_W'(1), 1'b1, 1'b0);
        // frame left at a position past the 8N1 length, then format switched
        push_symbol(DUR_W'(1), 1'b0, 1'b0);
        push_symbol(DUR_W'(10), 1'b1, 1'b0);
        settle();
        write_reg(CFG_FORMAT, CFG_DATA_W'(FMT_8N1));
        push_symbol(DUR_W'(3), 1'b0, 1'b0);
        settle();
        write_reg(CFG_FORMAT, CFG_DATA_W'(FMT_8E2));
        // zero baud mid-frame: every count is zero, so a high run pads
        push_symbol(DUR_W'(2), 1'b0, 1'b0);
        settle();
        write_reg(CFG_BAUD, '0);
        push_symbol(DUR_W'(500), 1'b1, 1'b0);
        push_symbol(DUR_W'(7), 1'b0, 1'b0);
        push_symbol('1, 1'b0, 1'b0);
        settle();
        // zero tick rate saturates every count
        write_reg(CFG_TICK, '0);
        push_symbol('0, 1'b0, 1'b0);
        repeat (6)
            push_symbol(DUR_W'($urandom), 1'($urandom), $urandom_range(3) == 0);
        settle();
        write_reg(CFG_BAUD, CFG_DATA_W'(1));
        write_reg(CFG_TICK, CFG_DATA_W'(1));
        random_traffic(50);
        settle();

        // no idling on either side, fast tick clock
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(CFG_BAUD, CFG_DATA_W'(250000));
        write_reg(CFG_TICK, CFG_DATA_W'(80000000));
        random_traffic(50);
        settle();
        write_reg(CFG_FORMAT, CFG_DATA_W'(FMT_8N1));
        random_traffic(50);
        settle();

        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
